// ===== rtl/lpcc_pkg.sv =====
package lpcc_pkg;

    localparam int COL_W      = 10;
    localparam int CHAR_W     = 8;
    localparam int NUM_SLOTS  = 6;
    localparam int SLOT_IDX_W = $clog2(NUM_SLOTS);
    localparam int PLACE_SLOTS = 3;
    localparam int CFG_ADDR_W = 1;

    localparam logic [COL_W-1:0] COL_LIMIT           = 10'd1000;
    localparam logic [COL_W-1:0] DEFAULT_MAX_COLUMNS = 10'd132;
    localparam logic [COL_W-1:0] TAB_STEP            = 10'd8;
    localparam logic [COL_W-1:0] TAB_MASK            = ~10'd7;

    // Register indexes on the configuration port
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_COLUMNS = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_UPPERCASE   = 1'd1;

    localparam logic [CHAR_W-1:0] CH_BS         = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB        = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF         = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_FF         = 8'h0C;
    localparam logic [CHAR_W-1:0] CH_CR         = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE      = 8'h20;
    localparam logic [CHAR_W-1:0] CH_BANG       = 8'h21;
    localparam logic [CHAR_W-1:0] CH_QUOTE      = 8'h27;
    localparam logic [CHAR_W-1:0] CH_LPAREN     = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAREN     = 8'h29;
    localparam logic [CHAR_W-1:0] CH_DASH       = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_CARET      = 8'h5E;
    localparam logic [CHAR_W-1:0] CH_BACKQUOTE  = 8'h60;
    localparam logic [CHAR_W-1:0] CH_LOWER_A    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_Z    = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_LBRACE     = 8'h7B;
    localparam logic [CHAR_W-1:0] CH_VBAR       = 8'h7C;
    localparam logic [CHAR_W-1:0] CH_RBRACE     = 8'h7D;
    localparam logic [CHAR_W-1:0] CH_TILDE      = 8'h7E;
    localparam logic [CHAR_W-1:0] CASE_OFFSET   = 8'h20;

    typedef struct packed {
        logic [COL_W-1:0] lc;
        logic [COL_W-1:0] pc;
        logic             page_empty;
    } t_col_state;

    typedef struct packed {
        logic              vld;
        logic [CHAR_W-1:0] ch;
        logic [COL_W-1:0]  rep;
    } t_slot;

endpackage

// ===== rtl/lpcc_place.sv =====
module lpcc_place
    import lpcc_pkg::*;
(
    input  logic [CHAR_W-1:0]        i_char,
    input  logic [COL_W-1:0]         i_max_columns,
    input  t_col_state               i_state,
    output t_col_state               o_state,
    output t_slot [PLACE_SLOTS-1:0]  o_slots
);

    logic [COL_W-1:0] lc;
    logic [COL_W-1:0] pc;
    logic             pe;

    // slot 0: carriage return, slot 1: space run, slot 2: the byte itself
    always_comb begin
        lc      = i_state.lc;
        pc      = i_state.pc;
        pe      = i_state.page_empty;
        o_slots = '0;
        case (i_char) inside
            CH_SPACE: begin
                lc = lc + 10'd1;
            end
            CH_TAB: begin
                lc = (lc + TAB_STEP) & TAB_MASK;
            end
            CH_LF, CH_FF: begin
                if (!(i_char == CH_FF && pe && pc == '0)) begin
                    o_slots[2] = '{vld: 1'b1, ch: i_char, rep: 10'd1};
                    pe = (i_char == CH_FF);
                    pc = '0;
                    lc = '0;
                end
            end
            CH_CR: begin
                lc = '0;
            end
            CH_BS: begin
                if (lc != '0) begin
                    lc = lc - 10'd1;
                end
            end
            default: begin
                // head is past the target: return to column zero first
                if (lc < pc) begin
                    o_slots[0] = '{vld: 1'b1, ch: CH_CR, rep: 10'd1};
                    pc = '0;
                end
                if (lc < i_max_columns) begin
                    if (lc > pc) begin
                        o_slots[1] = '{vld: 1'b1, ch: CH_SPACE, rep: lc - pc};
                    end
                    o_slots[2] = '{vld: 1'b1, ch: i_char, rep: 10'd1};
                    pc = lc + 10'd1;
                end
                lc = lc + 10'd1;
            end
        endcase
        if (lc > COL_LIMIT) begin
            lc = COL_LIMIT;
        end
        o_state = '{lc: lc, pc: pc, page_empty: pe};
    end

endmodule

// ===== rtl/line_printer_column_canonicalizer.sv =====
// An accepted item is first registered, then its results are loaded into the result buffer once that is free.
// An item holds the result buffer until all of its results (0 to 6) are taken;
// the next item enters the result buffer as the last result is taken.
// Both column trackers and the overstrike path are combinational; the column state is registered as an item moves.
// Reset (synchronous, active low): columns 0, page empty, max columns 132,
// uppercase mode off, no item pending.
module line_printer_column_canonicalizer
    import lpcc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_stall,
    input  logic [CHAR_W-1:0]     i_char_in,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [CHAR_W-1:0]     o_out_char,
    output logic [COL_W-1:0]      o_repeat_res,
    output logic                  o_last,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [COL_W-1:0]      i_cfg_data
);

    logic [COL_W-1:0]     r_max_columns;
    logic                 r_uppercase;
    t_col_state           r_state;
    logic                 r_in_valid;
    logic [CHAR_W-1:0]    r_char;
    logic [NUM_SLOTS-1:0] r_mask;
    logic [CHAR_W-1:0]    r_ch  [NUM_SLOTS];
    logic [COL_W-1:0]     r_rep [NUM_SLOTS];

    logic [NUM_SLOTS-1:0]    n_mask;
    logic [SLOT_IDX_W-1:0]   sel;
    logic                    take;
    logic                    move;
    logic                    has_sub;
    logic [CHAR_W-1:0]       sub_char;
    logic [CHAR_W-1:0]       main_char;
    t_col_state              sub_state;
    t_col_state              mid_state;
    t_col_state              next_state;
    t_slot [PLACE_SLOTS-1:0] sub_slots;
    t_slot [PLACE_SLOTS-1:0] main_slots;
    t_slot [NUM_SLOTS-1:0]   all_slots;

    // uppercase mapping and overstrike substitutes
    always_comb begin
        has_sub   = 1'b0;
        sub_char  = r_char;
        main_char = r_char;
        if (r_uppercase) begin
            has_sub = 1'b1;
            case (r_char) inside
                CH_LBRACE:    sub_char = CH_LPAREN;
                CH_RBRACE:    sub_char = CH_RPAREN;
                CH_BACKQUOTE: sub_char = CH_QUOTE;
                CH_VBAR:      sub_char = CH_BANG;
                CH_TILDE:     sub_char = CH_CARET;
                default:      has_sub = 1'b0;
            endcase
            if (has_sub) begin
                main_char = CH_DASH;
            end else if (r_char >= CH_LOWER_A && r_char <= CH_LOWER_Z) begin
                main_char = r_char - CASE_OFFSET;
            end
        end
    end

    lpcc_place u_place_sub (
        .i_char        (sub_char),
        .i_max_columns (r_max_columns),
        .i_state       (r_state),
        .o_state       (sub_state),
        .o_slots       (sub_slots)
    );

    // step back one column so the dash lands on the substitute
    always_comb begin
        mid_state = r_state;
        if (has_sub) begin
            mid_state = sub_state;
            if (sub_state.lc != '0) begin
                mid_state.lc = sub_state.lc - 10'd1;
            end
        end
    end

    lpcc_place u_place_main (
        .i_char        (main_char),
        .i_max_columns (r_max_columns),
        .i_state       (mid_state),
        .o_state       (next_state),
        .o_slots       (main_slots)
    );

    always_comb begin
        all_slots = {main_slots, sub_slots};
        if (!has_sub) begin
            for (int k = 0; k < PLACE_SLOTS; k++) begin
                all_slots[k].vld = 1'b0;
            end
        end
    end

    // lowest pending slot goes out first
    always_comb begin
        sel = '0;
        for (int k = NUM_SLOTS - 1; k >= 0; k--) begin
            if (r_mask[k]) begin
                sel = SLOT_IDX_W'(k);
            end
        end
    end

    assign o_valid      = |r_mask;
    assign o_last       = ((r_mask & (r_mask - NUM_SLOTS'(1))) == '0);
    assign o_out_char   = r_ch[sel];
    assign o_repeat_res = r_rep[sel];

    assign take    = o_valid && !i_stall;
    assign move    = r_in_valid && (!o_valid || (take && o_last));
    assign o_stall = r_in_valid && !move;

    always_comb begin
        n_mask = r_mask;
        if (move) begin
            for (int k = 0; k < NUM_SLOTS; k++) begin
                n_mask[k] = all_slots[k].vld;
            end
        end else if (take) begin
            n_mask[sel] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_columns <= DEFAULT_MAX_COLUMNS;
            r_uppercase   <= 1'b0;
            r_state       <= '{lc: '0, pc: '0, page_empty: 1'b1};
            r_in_valid    <= 1'b0;
            r_mask        <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_MAX_COLUMNS: r_max_columns <= i_cfg_data;
                    CFG_UPPERCASE:   r_uppercase   <= i_cfg_data[0];
                    default:         ;
                endcase
            end
            if (i_in_valid && !o_stall) begin
                r_in_valid <= 1'b1;
            end else if (move) begin
                r_in_valid <= 1'b0;
            end
            if (move) begin
                r_state <= next_state;
            end
            r_mask <= n_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_stall) begin
            r_char <= i_char_in;
        end
        if (move) begin
            for (int k = 0; k < NUM_SLOTS; k++) begin
                r_ch[k]  <= all_slots[k].ch;
                r_rep[k] <= all_slots[k].rep;
            end
        end
    end

endmodule

// ===== rtl/lpcc_checker.sv =====
module lpcc_checker
    import lpcc_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_valid,
    input logic                  i_stall,
    input logic [CHAR_W-1:0]     o_out_char,
    input logic [COL_W-1:0]      o_repeat_res,
    input logic                  o_last
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_char) && $stable(o_repeat_res)
            && $stable(o_last))
        else $error("stalled result changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // a space run always precedes the byte it positions
    a_pos_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_out_char == CH_SPACE) |-> !o_last)
        else $error("space run marked last");

    a_burst_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last && !i_stall |=> o_valid)
        else $error("result burst broken before last");

endmodule

bind line_printer_column_canonicalizer lpcc_checker u_lpcc_checker (.*);
